/* src/imm_pkg.sv */
// ----------------------------------------------------------------------------
// imm_pkg: shared types and constants for the integer matrix multiplier
// Dimension limits, register indexes, field widths, the front-to-back
// command record, the result record and the size clamp.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int VALUE_W     = 35;
    localparam int REG_W       = 4;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 2;

    localparam logic [IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [IDX_W-1:0] REG_COLS_B     = 2'd2;

    // Command from the loader to the compute engine: the sizes of one run.
    typedef struct packed {
        logic [DIM_W:0] m;
        logic [DIM_W:0] n;
        logic [DIM_W:0] p;
    } run_cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] product_value;
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic               last;
    } result_t;

    // Register value clamped into 1..MAX_DIM.
    function automatic logic [DIM_W:0] eff_dim(input logic [REG_W-1:0] r);
        logic [DIM_W:0] v;
        if (r == '0)
            v = (DIM_W+1)'(1);
        else if (r > REG_W'(MAX_DIM))
            v = (DIM_W+1)'(MAX_DIM);
        else
            v = (DIM_W+1)'(r);
        return v;
    endfunction

endpackage

/* src/imm_if.sv */
// ----------------------------------------------------------------------------
// imm_if: stream channel interfaces
// Valid/ready channels for elements, results and configuration writes.
// ----------------------------------------------------------------------------
interface imm_elem_if;
    logic                      valid;
    logic                      ready;
    logic signed [15:0]        element;
    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface imm_result_if;
    logic                      valid;
    logic                      ready;
    logic signed [34:0]        product_value;
    logic [2:0]                out_row;
    logic [2:0]                out_col;
    logic                      last;
    modport source (output valid, output product_value, output out_row,
                    output out_col, output last, input ready);
    modport sink   (input valid, input product_value, input out_row,
                    input out_col, input last, output ready);
endinterface

interface imm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                index;
    logic [3:0]                data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/imm_compute.sv */
// ----------------------------------------------------------------------------
// imm_compute: multiply-accumulate back end
// Holds the operand stores, takes one run command at a time and walks the
// product matrix, one registered multiply and accumulate per unstalled cycle.
// ----------------------------------------------------------------------------
module imm_compute (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          a_we,
    input  logic                          b_we,
    input  logic [imm_pkg::ADDR_W-1:0]    wr_addr,
    input  logic signed [15:0]            wr_data,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  imm_pkg::run_cmd_t             cmd,
    output logic                          res_valid,
    input  logic                          res_ready,
    output imm_pkg::result_t              res
);
    import imm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic signed [ELEM_W-1:0] a_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [STORE_DEPTH];

    logic [1:0]         state_reg, state_next;
    run_cmd_t           cmd_reg;
    logic [DIM_W-1:0]   i_reg, j_reg, k_reg;
    logic               issue_reg;      // operands read this cycle valid
    logic               mul_v_reg;      // product register valid
    logic               fin_reg;        // last product of entry in flight
    logic               mul_fin_reg;
    logic signed [ELEM_W-1:0]  a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0]  mul_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic               out_v_reg;
    result_t            out_reg;
    logic [DIM_W-1:0]   ri_reg, rj_reg;   // indices of entry being summed
    logic [DIM_W-1:0]   pi_reg, pj_reg;
    logic               k_end, j_end, i_end;
    logic [ADDR_W-1:0]  a_addr, b_addr;

    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[wr_addr] <= wr_data;
        if (b_we)
            b_mem[wr_addr] <= wr_data;
    end

    assign k_end = ({1'b0, k_reg} == cmd_reg.n - 1'b1);
    assign j_end = ({1'b0, j_reg} == cmd_reg.p - 1'b1);
    assign i_end = ({1'b0, i_reg} == cmd_reg.m - 1'b1);
    assign a_addr = ADDR_W'(i_reg) * ADDR_W'(cmd_reg.n) + ADDR_W'(k_reg);
    assign b_addr = ADDR_W'(k_reg) * ADDR_W'(cmd_reg.p) + ADDR_W'(j_reg);
    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_valid) state_next = ST_RUN;
            ST_RUN:  if (k_end) state_next = ST_OUT;
            ST_OUT:  if (out_v_reg && res_ready)
                     begin
                         state_next = (out_reg.last) ? ST_IDLE : ST_RUN;
                     end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issue_reg   <= 1'b0;
            mul_v_reg   <= 1'b0;
            fin_reg     <= 1'b0;
            mul_fin_reg <= 1'b0;
            out_v_reg   <= 1'b0;
            i_reg <= '0; j_reg <= '0; k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= (state_reg == ST_RUN);
            fin_reg   <= (state_reg == ST_RUN) && k_end;
            mul_v_reg <= issue_reg;
            mul_fin_reg <= fin_reg;
            if (state_reg == ST_IDLE && cmd_valid)
            begin
                i_reg <= '0; j_reg <= '0; k_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (k_end)
                begin
                    k_reg <= '0;
                    if (j_end)
                    begin
                        j_reg <= '0;
                        i_reg <= i_end ? '0 : i_reg + 1'b1;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
            if (mul_v_reg && mul_fin_reg)
                out_v_reg <= 1'b1;
            else if (out_v_reg && res_ready)
                out_v_reg <= 1'b0;
        end
    end

    // Datapath: read, multiply, accumulate; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
            cmd_reg <= cmd;
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
        ri_reg <= i_reg;
        rj_reg <= j_reg;
        pi_reg <= ri_reg;
        pj_reg <= rj_reg;
        mul_reg <= a_rd_reg * b_rd_reg;
        if (state_reg == ST_IDLE)
            acc_reg <= '0;
        else if (mul_v_reg)
        begin
            if (mul_fin_reg)
            begin
                out_reg.product_value <= acc_reg + VALUE_W'(mul_reg);
                out_reg.out_row <= 3'(pi_reg);
                out_reg.out_col <= 3'(pj_reg);
                out_reg.last <= ({1'b0, pi_reg} == cmd_reg.m - 1'b1)
                             && ({1'b0, pj_reg} == cmd_reg.p - 1'b1);
                acc_reg <= '0;
            end
            else
                acc_reg <= acc_reg + VALUE_W'(mul_reg);
        end
    end

    assign res_valid = out_v_reg;
    assign res       = out_reg;

    a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> state_reg == ST_RUN)
        else $error("command not started");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");
    a_no_run_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> !out_v_reg)
        else $error("summing with result pending");
endmodule

/* src/imm_loader.sv */
// ----------------------------------------------------------------------------
// imm_loader: element intake and configuration
// Holds the size registers, counts incoming elements into the A and B
// stores and posts a run command into a one-entry queue when B is complete.
// ----------------------------------------------------------------------------
module imm_loader (
    input  logic                          clk,
    input  logic                          rst_n,
    imm_elem_if.sink                      in_ch,
    imm_cfg_if.sink                       cfg,
    output logic                          a_we,
    output logic                          b_we,
    output logic [imm_pkg::ADDR_W-1:0]    wr_addr,
    output logic signed [15:0]            wr_data,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output imm_pkg::run_cmd_t             cmd
);
    import imm_pkg::*;

    logic [REG_W-1:0] rows_a_reg, inner_size_reg, cols_b_reg;
    logic [CNT_W-1:0] load_count_reg, count_inc;
    logic             loading_b_reg;
    logic             q_valid_reg;
    run_cmd_t         q_reg, sizes;
    logic             accept, done_a, done_b;

    assign sizes.m = eff_dim(rows_a_reg);
    assign sizes.n = eff_dim(inner_size_reg);
    assign sizes.p = eff_dim(cols_b_reg);

    // Take no element while a run waits in the queue or the engine has not yet
    // gone back to idle after sending the last entry of its run.
    assign in_ch.ready = !q_valid_reg && cmd_ready;
    assign cfg.ready   = 1'b1;
    assign accept      = in_ch.valid && in_ch.ready;
    assign count_inc   = load_count_reg + 1'b1;
    assign done_a = {1'b0, count_inc} >= (CNT_W+1)'(sizes.m) * (CNT_W+1)'(sizes.n);
    assign done_b = {1'b0, count_inc} >= (CNT_W+1)'(sizes.n) * (CNT_W+1)'(sizes.p);

    assign a_we    = accept && !loading_b_reg;
    assign b_we    = accept && loading_b_reg;
    assign wr_addr = load_count_reg[ADDR_W-1:0];
    assign wr_data = in_ch.element;
    assign cmd_valid = q_valid_reg;
    assign cmd       = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg     <= REG_W'(MAX_DIM);
            inner_size_reg <= REG_W'(MAX_DIM);
            cols_b_reg     <= REG_W'(MAX_DIM);
            load_count_reg <= '0;
            loading_b_reg  <= 1'b0;
            q_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_ROWS_A:     rows_a_reg     <= cfg.data;
                    REG_INNER_SIZE: inner_size_reg <= cfg.data;
                    REG_COLS_B:     cols_b_reg     <= cfg.data;
                    default: ;
                endcase
            end
            if (q_valid_reg && cmd_ready)
                q_valid_reg <= 1'b0;
            if (accept)
            begin
                if (!loading_b_reg && done_a)
                begin
                    loading_b_reg  <= 1'b1;
                    load_count_reg <= '0;
                end
                else if (loading_b_reg && done_b)
                begin
                    loading_b_reg  <= 1'b0;
                    load_count_reg <= '0;
                    q_valid_reg    <= 1'b1;
                end
                else
                    load_count_reg <= count_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && loading_b_reg && done_b)
            q_reg <= sizes;
    end

    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg |-> !accept)
        else $error("element taken while run pending");
    a_post: assert property (@(posedge clk) disable iff (!rst_n)
        accept && loading_b_reg && done_b |=> q_valid_reg && !loading_b_reg)
        else $error("run not posted");
    a_we_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(a_we && b_we))
        else $error("both stores written");
endmodule

/* src/integer_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// integer_matrix_multiply: signed 16-bit matrix product engine
// Loads A then B one element a beat and streams the exact product.
// ----------------------------------------------------------------------------
// Elements are taken one a beat into the A and B stores. When B completes,
// the loader hands the run to the compute engine and stops taking elements
// until the engine has sent the last entry of the product. The engine does
// one multiply-accumulate per cycle from its operand stores while it sums an
// entry; each entry then drains through the operand read, multiply and
// accumulate registers and the engine waits until its result beat is taken,
// so a stall on the result side holds the run. Loading takes M*N+N*P
// elements. Entries leave in row-major order.
module integer_matrix_multiply (
    input  logic        clk,
    input  logic        rst_n,
    imm_elem_if.sink    in_ch,
    imm_result_if.source out_ch,
    imm_cfg_if.sink     cfg
);
    import imm_pkg::*;

    logic                    a_we, b_we, cmd_valid, cmd_ready;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [15:0]      wr_data;
    run_cmd_t                cmd;
    result_t                 res;

    imm_loader u_loader (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg(cfg),
        .a_we(a_we), .b_we(b_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    imm_compute u_compute (
        .clk(clk), .rst_n(rst_n), .a_we(a_we), .b_we(b_we),
        .wr_addr(wr_addr), .wr_data(wr_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
    );

    assign out_ch.product_value = res.product_value;
    assign out_ch.out_row       = res.out_row;
    assign out_ch.out_col       = res.out_col;
    assign out_ch.last          = res.last;
endmodule

/* tb/tb_integer_matrix_multiply.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_matrix_multiply: self-checking bench for the matrix multiplier
// Streams A and B matrices under several size settings, predicts every
// product entry and checks each result beat field by field, with random
// idling on both the element and the result side.
// ----------------------------------------------------------------------------
module tb_integer_matrix_multiply;
    import imm_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    imm_elem_if   elem_ch ();
    imm_result_if res_ch ();
    imm_cfg_if    cfg_ch ();

    integer_matrix_multiply i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (elem_ch.sink),
        .out_ch (res_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    // sizes as written and the predictor's copy of the stores
    logic [3:0]         reg_rows, reg_inner, reg_cols;
    logic signed [15:0] a_store [STORE_DEPTH];
    logic signed [15:0] b_store [STORE_DEPTH];
    int                 fill_count;
    bit                 filling_b;
    result_t            entry_q [$];

    int  mismatches = 0;
    int  entries_seen = 0;
    int  runs_done = 0;
    int  cycle_count = 0;
    bit  quiet_idle = 1'b0;

    function automatic int clamp_dim(input logic [3:0] r);
        if (r == 4'd0)
            return 1;
        if (r > 4'd8)
            return MAX_DIM;
        return int'(r);
    endfunction

    // Absorb one element; on the last B element queue the whole product.
    function automatic void predict_product(input logic signed [15:0] v);
        int m, n, p;
        logic signed [34:0] acc;
        result_t r;
        m = clamp_dim(reg_rows);
        n = clamp_dim(reg_inner);
        p = clamp_dim(reg_cols);
        if (!filling_b) begin
            a_store[fill_count % STORE_DEPTH] = v;
            fill_count = (fill_count + 1) & 7'h7f;
            if (fill_count >= m * n) begin
                filling_b = 1'b1;
                fill_count = 0;
            end
            return;
        end
        b_store[fill_count % STORE_DEPTH] = v;
        fill_count = (fill_count + 1) & 7'h7f;
        if (fill_count < n * p)
            return;
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < p; j++) begin
                acc = '0;
                for (int k = 0; k < n; k++)
                    acc += 35'(a_store[i * n + k]) * 35'(b_store[k * p + j]);
                r.product_value = acc;
                r.out_row = 3'(i);
                r.out_col = 3'(j);
                r.last = (i == m - 1 && j == p - 1);
                entry_q.push_back(r);
            end
        end
        filling_b = 1'b0;
        fill_count = 0;
        runs_done++;
    endfunction

    initial
    begin
        elem_ch.valid   = 1'b0;
        elem_ch.element = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_ROWS_A;
        cfg_ch.data     = '0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result sink: random stalls, compare against oldest expected entry
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            entries_seen++;
            if (entry_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat row %0d col %0d",
                             res_ch.out_row, res_ch.out_col);
            end
            else begin
                result_t want;
                want = entry_q.pop_front();
                if (res_ch.product_value !== want.product_value
                        || res_ch.out_row !== want.out_row
                        || res_ch.out_col !== want.out_col
                        || res_ch.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d r%0d c%0d l%0b got %0d r%0d c%0d l%0b",
                                 $signed(want.product_value), want.out_row,
                                 want.out_col, want.last,
                                 res_ch.product_value, res_ch.out_row,
                                 res_ch.out_col, res_ch.last);
                end
            end
        end
        res_ch.ready <= quiet_idle || ($urandom_range(99) >= 16);
    end

    // valid stays up after the beat; idling or draining drops it
    task automatic send_element(input logic signed [15:0] v);
        if (!quiet_idle)
            while ($urandom_range(99) < 16) begin
                elem_ch.valid <= 1'b0;
                @(posedge clk);
            end
        elem_ch.valid   <= 1'b1;
        elem_ch.element <= v;
        do
            @(posedge clk);
        while (!elem_ch.ready);
        predict_product(v);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_ROWS_A:     reg_rows  = val;
            REG_INNER_SIZE: reg_inner = val;
            default:        reg_cols  = val;
        endcase
    endtask

    task automatic drain_results();
        elem_ch.valid <= 1'b0;
        while (entry_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_sizes(input logic [3:0] m, input logic [3:0] n,
                             input logic [3:0] p);
        drain_results();
        write_register(REG_ROWS_A, m);
        write_register(REG_INNER_SIZE, n);
        write_register(REG_COLS_B, p);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] random_element();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_pair(input bit extreme);
        int total;
        total = clamp_dim(reg_rows) * clamp_dim(reg_inner)
              + clamp_dim(reg_inner) * clamp_dim(reg_cols);
        for (int e = 0; e < total; e++)
            send_element(extreme ? 16'sh8000 : random_element());
    endtask

    // 1x1x1 with both extremes, then largest extremes sums
    task automatic test_directed_extremes();
        set_sizes(4'd1, 4'd1, 4'd1);
        send_element(16'sh8000);
        send_element(16'sh8000);
        send_element(16'sh7fff);
        send_element(16'sh8000);
        send_element(16'sh0000);
        send_element(16'shffff);
        // zero and out-of-range registers clamp to 1 and 8
        set_sizes(4'd0, 4'd15, 4'd0);
        send_pair(1'b1);
    endtask

    task automatic test_full_size_extremes();
        set_sizes(4'd8, 4'd8, 4'd8);
        send_pair(1'b1);
        // hold off until every entry has come back
        drain_results();
        // one long stretch with no idling on either side
        quiet_idle = 1'b1;
        send_pair(1'b0);
        drain_results();
        quiet_idle = 1'b0;
    endtask

    task automatic test_random_sizes();
        int sent;
        sent = 0;
        while (sent < 80) begin
            set_sizes(4'($urandom_range(1, 4)), 4'($urandom_range(1, 4)),
                      4'($urandom_range(1, 4)));
            quiet_idle = ($urandom_range(4) == 0);
            for (int r = 0; r < 3; r++) begin
                send_pair(1'b0);
                sent += clamp_dim(reg_rows) * clamp_dim(reg_inner)
                      + clamp_dim(reg_inner) * clamp_dim(reg_cols);
            end
            quiet_idle = 1'b0;
        end
    endtask

    initial
    begin
        reg_rows = 4'd8;
        reg_inner = 4'd8;
        reg_cols = 4'd8;
        fill_count = 0;
        filling_b = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_full_size_extremes();
        test_random_sizes();
        drain_results();
        $display("Covered %0d matrix products, %0d entries checked, sizes 1..8.",
                 runs_done, entries_seen);
        if (mismatches == 0 && entry_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* integer_matrix_multiply.f */
src/imm_pkg.sv
src/imm_if.sv
src/imm_compute.sv
src/imm_loader.sv
src/integer_matrix_multiply.sv
tb/tb_integer_matrix_multiply.sv
